>>> rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, and the beat and entry types shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY       = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int COUNT_WIDTH    = $clog2(CAPACITY + 1);

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_REMOVED  = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  // Request beat.
  typedef struct packed {
    command_t           command;
    logic [31:0]        item_value;
    logic signed [15:0] item_priority;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [31:0] out_value;
    status_t     status;
    logic [4:0]  occupancy;
  } rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0]           value;
    logic signed [PRIORITY_WIDTH-1:0] prio;
  } entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert it takes the new entry or its left neighbor's,
// on removal it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_ins,
  input  wire spq_pkg::entry_t    left_data,
  input  wire spq_pkg::entry_t    right_data,
  output logic                    ins,
  output spq_pkg::entry_t         data
);

  // Cells are kept in descending priority order from cell zero, so this flag
  // is false over a prefix of the chain and true from the insert point on.
  always_comb begin
    ins = !occupied || ($signed(data.prio) <= $signed(ctrl.new_entry.prio));
  end

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (ins && !left_ins) begin
        data <= ctrl.new_entry;
      end else if (ins) begin
        data <= left_data;
      end
    end else if (ctrl.deq) begin
      data <= right_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sorted_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded priority queue built as a shift-register chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on req carries a command: enqueue stores item_value with
//   the signed item_priority, dequeue removes the entry of highest priority.
//   Among equal priorities the entry inserted last is removed first.
//   Every request yields exactly one response beat on rsp, carrying the
//   removed value (zero unless an entry was removed), a status (inserted,
//   removed, empty on dequeue, full on enqueue) and the occupancy after the
//   command.
//   The response is valid in the cycle after the request is accepted.
//   Throughput is one request per cycle while the receiver takes each
//   response, since every cell compares and shifts in the same cycle; the
//   response register is the only stage.
//   When the receiver stalls, the response is held in its register and
//   req_ready stays low until it is taken; a request is still accepted in
//   the cycle in which the waiting response leaves.
//   Reset empties the queue and drops any pending response. Cell contents
//   are not cleared; only cells below the entry count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire spq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output spq_pkg::rsp_t      rsp
);

  logic [spq_pkg::COUNT_WIDTH-1:0] count;
  logic [spq_pkg::COUNT_WIDTH-1:0] count_next;
  spq_pkg::rsp_t                   rsp_next;
  spq_pkg::cell_ctrl_t             ctrl;
  logic                            accept;
  logic                            full;
  logic                            empty;

  spq_pkg::entry_t cell_data [spq_pkg::CAPACITY];
  logic            cell_ins  [spq_pkg::CAPACITY];

  // The response register frees up in the same cycle it is drained.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == spq_pkg::COUNT_WIDTH'(spq_pkg::CAPACITY));
  assign empty     = (count == '0);

  // Fit the request fields to the stored widths: the value is truncated or
  // zero extended, the priority truncated or sign extended.
  always_comb begin
    logic [spq_pkg::VALUE_WIDTH+31:0]    value_ext;
    logic [spq_pkg::PRIORITY_WIDTH+15:0] prio_ext;
    value_ext = {{spq_pkg::VALUE_WIDTH{1'b0}}, req.item_value};
    prio_ext  = {{spq_pkg::PRIORITY_WIDTH{req.item_priority[15]}}, req.item_priority};
    ctrl.new_entry.value = value_ext[spq_pkg::VALUE_WIDTH-1:0];
    ctrl.new_entry.prio  = prio_ext[spq_pkg::PRIORITY_WIDTH-1:0];
    ctrl.enq = accept && (req.command == spq_pkg::CMD_ENQUEUE) && !full;
    ctrl.deq = accept && (req.command == spq_pkg::CMD_DEQUEUE) && !empty;
  end

  // The chain: cell zero holds the highest priority. An insert pushes the
  // cells at and beyond the insert point one place to the right; a removal
  // takes cell zero and pulls every cell one place to the left.
  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic            occupied;
    logic            left_ins;
    spq_pkg::entry_t left_data;
    spq_pkg::entry_t right_data;

    assign occupied = (count > spq_pkg::COUNT_WIDTH'(i));

    if (i == 0) begin : g_first
      assign left_ins  = 1'b0;
      assign left_data = ctrl.new_entry;
    end else begin : g_inner
      assign left_ins  = cell_ins[i-1];
      assign left_data = cell_data[i-1];
    end

    // The last cell has nobody to its right; what it takes on a removal lies
    // beyond the entry count and is never read.
    if (i == spq_pkg::CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .left_ins   (left_ins),
      .left_data  (left_data),
      .right_data (right_data),
      .ins        (cell_ins[i]),
      .data       (cell_data[i])
    );
  end

  // Count update and response forming.
  always_comb begin
    logic [spq_pkg::VALUE_WIDTH+31:0] out_ext;
    logic [spq_pkg::COUNT_WIDTH+4:0]  occ_ext;
    out_ext    = {32'd0, cell_data[0].value};
    count_next = count;
    rsp_next.out_value = '0;
    if (req.command == spq_pkg::CMD_ENQUEUE) begin
      if (full) begin
        rsp_next.status = spq_pkg::STATUS_FULL;
      end else begin
        rsp_next.status = spq_pkg::STATUS_INSERTED;
        count_next      = count + spq_pkg::COUNT_WIDTH'(1);
      end
    end else begin
      if (empty) begin
        rsp_next.status = spq_pkg::STATUS_EMPTY;
      end else begin
        rsp_next.status    = spq_pkg::STATUS_REMOVED;
        rsp_next.out_value = out_ext[31:0];
        count_next         = count - spq_pkg::COUNT_WIDTH'(1);
      end
    end
    occ_ext            = {5'd0, count_next};
    rsp_next.occupancy = occ_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire
